@@ src/jdn_pkg.sv @@
// Shared types, stage count and constants for the Julian day number converter.
// Used by every module in src; depends on nothing else.
package jdn_pkg;

	// Pipeline depth from request accept to result register
	localparam int NUM_STAGES = 6;

	// Per-stage load enables, driven by the pipeline control
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} jdn_ctrl_t;

	// Conversion direction carried with each request
	typedef enum logic {
		FUNC_DATE_TO_DN = 1'b0,
		FUNC_DN_TO_DATE = 1'b1
	} jdn_func_t;

	// Forward direction offsets
	localparam logic signed [25:0] DN_OFFSET   = 26'sd32075;
	localparam logic signed [15:0] YEAR_BASE_A = 16'sd4800;
	localparam logic signed [15:0] YEAR_BASE_B = 16'sd4900;
	localparam logic signed [25:0] QUAD_YEAR   = 26'sd1461;

	// Truncating divide of a 15-bit magnitude by 100 (exact for values below 2^15)
	localparam int              C100_SHIFT = 22;
	localparam logic [15:0]     C100_MULT  =
		16'(((64'd1 << C100_SHIFT) + 64'd99) / 64'd100);

	// Reverse direction constants
	localparam logic [23:0] DN_EPOCH_ADJ = 24'd68569;
	localparam logic [17:0] DAYS_400Y    = 18'd146097;
	localparam logic [17:0] QUAD_DAYS    = 18'd1461;
	localparam logic [15:0] MONTH_BIAS   = 16'd31;
	localparam logic signed [15:0] CENTURY_BIAS = 16'sd4900;
	localparam logic signed [15:0] CENTURY_LEN  = 16'sd100;

	// floor(4*l / 146097) as (l * NQ_MULT) >> NQ_SHIFT, exact for l below 2^24
	localparam int          NQ_SHIFT = 44;
	localparam logic [28:0] NQ_MULT  =
		29'(((64'd4 << NQ_SHIFT) + 64'd146096) / 64'd146097);

	// floor(4000*x / 1461001) as (x * IQ_MULT) >> IQ_SHIFT, exact for x below 2^16
	localparam int          IQ_SHIFT = 40;
	localparam logic [31:0] IQ_MULT  =
		32'(((64'd4000 << IQ_SHIFT) + 64'd1461000) / 64'd1461001);

	// floor(80*x / 2447) as (x * JQ_MULT) >> JQ_SHIFT, exact for x below 2^9
	localparam int          JQ_SHIFT = 24;
	localparam logic [19:0] JQ_MULT  =
		20'(((64'd80 << JQ_SHIFT) + 64'd2446) / 64'd2447);

	// 367 * (m - 2 - 12*a) / 12 for every 4-bit month code
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] v;
		case (m)
			4'd0:    v = 9'd305;
			4'd1:    v = 9'd336;
			4'd2:    v = 9'd367;
			4'd3:    v = 9'd30;
			4'd4:    v = 9'd61;
			4'd5:    v = 9'd91;
			4'd6:    v = 9'd122;
			4'd7:    v = 9'd152;
			4'd8:    v = 9'd183;
			4'd9:    v = 9'd214;
			4'd10:   v = 9'd244;
			4'd11:   v = 9'd275;
			4'd12:   v = 9'd305;
			4'd13:   v = 9'd336;
			4'd14:   v = 9'd367;
			default: v = 9'd397;
		endcase
		return v;
	endfunction

	// 2447 * j / 80: days before month index j in the March-based year
	function automatic logic [8:0] mday_offset(input logic [3:0] j);
		logic [8:0] v;
		case (j)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd30;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd91;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd152;
			4'd6:    v = 9'd183;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd244;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd305;
			4'd11:   v = 9'd336;
			4'd12:   v = 9'd367;
			4'd13:   v = 9'd397;
			4'd14:   v = 9'd428;
			default: v = 9'd458;
		endcase
		return v;
	endfunction

endpackage

@@ src/julian_day_number_converter_core.sv @@
// Top level of the Julian day number converter: control plus both datapaths.
// Depends on jdn_pkg, jdn_ctrl, jdn_fwd and jdn_rev.
//
// Usage:
//   Each request on the input channel (in_valid/in_ready) carries func and the
//   fields of both directions. func = 0 converts day_in, month_in, year_in to
//   a Julian day number; func = 1 converts day_number_in to day, month and year
//   (years of zero or less come out lowered by one for BC numbering).
//   Each request gives one result on the output channel (out_valid/out_ready);
//   fields of the unused direction read as zero.
//   out_valid rises once an accepted request has reached the last of the six
//   register stages; the reverse reciprocal-multiply chain sets this depth,
//   and the forward path is padded to match. Throughput is one request per
//   cycle while the receiver does not stall.
//   Asynchronous reset empties all stages; nothing is pending afterwards.
//   When the receiver stalls, the last stage holds its result and earlier
//   stages keep filling bubbles; in_ready drops only once every stage is full.
module julian_day_number_converter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [4:0]         day_in,
	input  logic [3:0]         month_in,
	input  logic signed [14:0] year_in,
	input  logic [22:0]        day_number_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [22:0]        day_number_out,
	output logic [4:0]         day_out,
	output logic [3:0]         month_out,
	output logic signed [14:0] year_out
);
	import jdn_pkg::*;

	jdn_ctrl_t          ctrl;
	jdn_func_t          func_s6;
	logic [22:0]        fwd_dn;
	logic [4:0]         rev_day;
	logic [3:0]         rev_month;
	logic signed [14:0] rev_year;

	jdn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.func_out  (func_s6),
		.ctrl      (ctrl)
	);

	jdn_fwd u_fwd (
		.clk        (clk),
		.ctrl       (ctrl),
		.day_in     (day_in),
		.month_in   (month_in),
		.year_in    (year_in),
		.day_number (fwd_dn)
	);

	jdn_rev u_rev (
		.clk           (clk),
		.ctrl          (ctrl),
		.day_number_in (day_number_in),
		.day           (rev_day),
		.month         (rev_month),
		.year          (rev_year)
	);

	// Zero the fields of the direction not selected
	always_comb begin
		day_number_out = '0;
		day_out        = '0;
		month_out      = '0;
		year_out       = '0;
		case (func_s6)
			FUNC_DATE_TO_DN: begin
				day_number_out = fwd_dn;
			end
			default: begin
				day_out   = rev_day;
				month_out = rev_month;
				year_out  = rev_year;
			end
		endcase
	end

endmodule

@@ src/jdn_ctrl.sv @@
// Pipeline control: per-stage valid bits, load enables and the direction bit.
// Depends on jdn_pkg.
module jdn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	output logic               out_valid,
	input  logic               out_ready,
	output jdn_pkg::jdn_func_t func_out,
	output jdn_pkg::jdn_ctrl_t ctrl
);
	import jdn_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	jdn_func_t             func_q [NUM_STAGES];
	logic [NUM_STAGES-1:0] load;

	// Load a stage when it is empty or its contents move on this cycle
	always_comb begin
		load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Carry the direction of each request alongside its valid bit
	always_ff @(posedge clk) begin
		if (load[0]) begin
			func_q[0] <= jdn_func_t'(func);
		end
		for (int k = 1; k < NUM_STAGES; k++) begin
			if (load[k]) begin
				func_q[k] <= func_q[k-1];
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = valid_q[NUM_STAGES-1];
	assign func_out  = func_q[NUM_STAGES-1];
	assign ctrl.load = load;

endmodule

@@ src/jdn_fwd.sv @@
// Date to Julian day number datapath, computed in three stages and delayed to
// the common pipeline depth. Depends on jdn_pkg.
module jdn_fwd (
	input  logic               clk,
	input  jdn_pkg::jdn_ctrl_t ctrl,
	input  logic [4:0]         day_in,
	input  logic [3:0]         month_in,
	input  logic signed [14:0] year_in,
	output logic [22:0]        day_number
);
	import jdn_pkg::*;

	// Stage 1 signals
	logic               a_neg;
	logic signed [15:0] a_val;
	logic signed [15:0] yr_ext;
	logic signed [15:0] ya;
	logic signed [15:0] yb;
	logic [14:0]        yb_mag;
	logic signed [25:0] p1;
	logic [30:0]        prod100;

	logic signed [25:0] p1_s1;
	logic [30:0]        prod100_s1;
	logic               neg_s1;
	logic [8:0]         t2_s1;
	logic [4:0]         day_s1;

	// Stage 2 signals
	logic signed [25:0] p1_adj;
	logic [7:0]         q100;
	logic signed [8:0]  qs;

	logic signed [23:0] t1_s2;
	logic signed [8:0]  qs_s2;
	logic [8:0]         t2_s2;
	logic [4:0]         day_s2;

	// Stage 3 signals
	logic signed [10:0] m3;
	logic signed [10:0] m3_adj;
	logic signed [8:0]  t3;
	logic signed [25:0] sum;

	logic [22:0] dn_s3;
	logic [22:0] dn_s4;
	logic [22:0] dn_s5;
	logic [22:0] dn_s6;

	// Stage 1: month correction, year products, magnitude divide by 100
	always_comb begin
		a_neg   = (month_in <= 4'd2);
		a_val   = a_neg ? -16'sd1 : 16'sd0;
		yr_ext  = 16'(year_in);
		ya      = yr_ext + YEAR_BASE_A + a_val;
		yb      = yr_ext + YEAR_BASE_B + a_val;
		yb_mag  = yb[15] ? 15'(-yb) : yb[14:0];
		p1      = 26'(ya) * QUAD_YEAR;
		prod100 = 31'(yb_mag) * 31'(C100_MULT);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			p1_s1      <= p1;
			prod100_s1 <= prod100;
			neg_s1     <= yb[15];
			t2_s1      <= month_offset(month_in);
			day_s1     <= day_in;
		end
	end

	// Stage 2: truncate both quotients toward zero
	always_comb begin
		p1_adj = p1_s1 + (p1_s1[25] ? 26'sd3 : 26'sd0);
		q100   = prod100_s1[C100_SHIFT +: 8];
		qs     = neg_s1 ? -$signed({1'b0, q100}) : $signed({1'b0, q100});
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			t1_s2  <= p1_adj[25:2];
			qs_s2  <= qs;
			t2_s2  <= t2_s1;
			day_s2 <= day_s1;
		end
	end

	// Stage 3: century term and final sum
	always_comb begin
		m3     = 11'(qs_s2) * 11'sd3;
		m3_adj = m3 + (m3[10] ? 11'sd3 : 11'sd0);
		t3     = m3_adj[10:2];
		sum    = $signed({21'd0, day_s2}) - DN_OFFSET + 26'(t1_s2)
			+ $signed({17'd0, t2_s2}) - 26'(t3);
	end

	// Hold the result through the remaining stages
	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			dn_s3 <= sum[22:0];
		end
		if (ctrl.load[3]) begin
			dn_s4 <= dn_s3;
		end
		if (ctrl.load[4]) begin
			dn_s5 <= dn_s4;
		end
		if (ctrl.load[5]) begin
			dn_s6 <= dn_s5;
		end
	end

	assign day_number = dn_s6;

endmodule

@@ src/jdn_rev.sv @@
// Julian day number to date datapath, six stages of reciprocal multiplies.
// Depends on jdn_pkg.
module jdn_rev (
	input  logic               clk,
	input  jdn_pkg::jdn_ctrl_t ctrl,
	input  logic [22:0]        day_number_in,
	output logic [4:0]         day,
	output logic [3:0]         month,
	output logic signed [14:0] year
);
	import jdn_pkg::*;

	logic [23:0] l;
	logic [52:0] prod_n;
	logic [23:0] l_s1;
	logic [52:0] prod_n_s1;

	logic [7:0]  n;
	logic [25:0] m146;
	logic [23:0] l_s2;
	logic [7:0]  n_s2;
	logic [25:0] m146_s2;

	logic [25:0] m146_rnd;
	logic [23:0] l2_full;
	logic [15:0] l2;
	logic [47:0] prod_i;
	logic [47:0] prod_i_s3;
	logic [15:0] l2_s3;
	logic [7:0]  n_s3;

	logic [6:0]  i;
	logic [17:0] qi;
	logic [15:0] l3_full;
	logic [8:0]  l3_s4;
	logic [6:0]  i_s4;
	logic [7:0]  n_s4;

	logic [28:0] prod_j;
	logic [28:0] prod_j_s5;
	logic [8:0]  l3_s5;
	logic [6:0]  i_s5;
	logic [7:0]  n_s5;

	logic [3:0]         j;
	logic [8:0]         k;
	logic               l4;
	logic [3:0]         mon;
	logic signed [15:0] yr;
	logic signed [15:0] yr_bc;
	logic [4:0]         day_s6;
	logic [3:0]         month_s6;
	logic signed [14:0] year_s6;

	// Stage 1: shift epoch, start 400-year cycle count
	always_comb begin
		l      = 24'(day_number_in) + DN_EPOCH_ADJ;
		prod_n = 53'(l) * 53'(NQ_MULT);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			l_s1      <= l;
			prod_n_s1 <= prod_n;
		end
	end

	// Stage 2: cycle count and days in whole cycles
	always_comb begin
		n    = prod_n_s1[NQ_SHIFT +: 8];
		m146 = 26'(n) * 26'(DAYS_400Y);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			l_s2    <= l_s1;
			n_s2    <= n;
			m146_s2 <= m146;
		end
	end

	// Stage 3: day within cycle, start year-in-cycle estimate
	always_comb begin
		m146_rnd = m146_s2 + 26'd3;
		l2_full  = l_s2 - m146_rnd[25:2];
		l2       = l2_full[15:0];
		prod_i   = 48'(l2 + 16'd1) * 48'(IQ_MULT);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			prod_i_s3 <= prod_i;
			l2_s3     <= l2;
			n_s3      <= n_s2;
		end
	end

	// Stage 4: year in cycle and day within March-based year
	always_comb begin
		i       = prod_i_s3[IQ_SHIFT +: 7];
		qi      = 18'(i) * QUAD_DAYS;
		l3_full = l2_s3 - qi[17:2] + MONTH_BIAS;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			l3_s4 <= l3_full[8:0];
			i_s4  <= i;
			n_s4  <= n_s3;
		end
	end

	// Stage 5: start month index estimate
	assign prod_j = 29'(l3_s4) * 29'(JQ_MULT);

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			prod_j_s5 <= prod_j;
			l3_s5     <= l3_s4;
			i_s5      <= i_s4;
			n_s5      <= n_s4;
		end
	end

	// Stage 6: day, month, year with BC numbering
	always_comb begin
		j     = prod_j_s5[JQ_SHIFT +: 4];
		k     = l3_s5 - mday_offset(j);
		l4    = (j >= 4'd11);
		mon   = l4 ? (j - 4'd10) : (j + 4'd2);
		yr    = $signed(16'(n_s5)) * CENTURY_LEN - CENTURY_BIAS
			+ $signed({9'd0, i_s5}) + $signed({15'd0, l4});
		yr_bc = (yr <= 16'sd0) ? (yr - 16'sd1) : yr;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			day_s6   <= k[4:0];
			month_s6 <= mon;
			year_s6  <= yr_bc[14:0];
		end
	end

	assign day   = day_s6;
	assign month = month_s6;
	assign year  = year_s6;

endmodule
